@@ rtl/bpc_pkg.sv @@
// shared types and constants for the button press classifier
// no dependencies; imported by every module of the block
package bpc_pkg;

    localparam int TIME_W   = 32;
    localparam int MS_W     = 16;
    localparam int IN_W     = 40;   // raw_level + time_ms + begin_suppress, byte padded
    localparam int OUT_W    = 8;    // press_event + suppressed + debounced_level, byte padded
    localparam int EV_W     = 3;
    localparam int TAP_W    = 2;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    typedef logic [EV_W-1:0] t_event;

    localparam t_event EV_NONE         = 3'd0;
    localparam t_event EV_SINGLE       = 3'd1;
    localparam t_event EV_DOUBLE       = 3'd2;
    localparam t_event EV_LONG         = 3'd3;
    localparam t_event EV_LONG_RELEASE = 3'd4;

    typedef enum logic [1:0] {
        REG_DEBOUNCE  = 2'd0,
        REG_LONG      = 2'd1,
        REG_DOUBLE    = 2'd2,
        REG_SINGLE_ON = 2'd3
    } t_reg_idx;

    localparam logic [MS_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [MS_W-1:0] LONG_RST     = 16'd1000;
    localparam logic [MS_W-1:0] DOUBLE_RST   = 16'd300;

    typedef struct packed {
        logic [MS_W-1:0] debounce_ms;
        logic [MS_W-1:0] long_press_ms;
        logic [MS_W-1:0] double_tap_ms;
        logic            single_on_release;
    } t_cfg;

    typedef struct packed {
        logic              last_raw_level;
        logic              stable_level;
        logic [TIME_W-1:0] change_stamp;
        logic [TIME_W-1:0] press_stamp;
        logic [TIME_W-1:0] first_tap_stamp;
        logic [TAP_W-1:0]  tap_counter;
        logic              long_fired;
        logic              awaiting_second_tap;
        logic              suppress_flag;
    } t_state;

    typedef struct packed {
        logic              raw_level;
        logic [TIME_W-1:0] time_ms;
        logic              begin_suppress;
    } t_sample;

    typedef struct packed {
        t_event press_event;
        logic   suppressed;
        logic   debounced_level;
    } t_result;

    localparam t_state STATE_RST = '0;

endpackage

@@ rtl/button_press_classifier_unit.sv @@
// top level of the button press classifier: stream ports, state and result registers
// depends on bpc_pkg, bpc_cfg and bpc_step
//
// usage:
//   s_* carries one button sample per transfer: raw level, 32-bit ms time stamp and
//   a begin-suppress flag. m_* returns exactly one result per sample, in order:
//   press event code, suppressed flag and debounced level.
//   registers (debounce, long press, double tap, single on release) sit on the apb-style
//   port; the user writes them only while no sample is in flight; the block does not enforce it.
// datapath and throughput:
//   a sample is held in an input register, classified combinationally against the
//   state registers, and lands in the result register, where m_tvalid rises with it.
//   one sample per cycle is sustained while m_tready stays high; the state update is a
//   single pass of three 32-bit subtract-compares between the two registers.
// reset:
//   i_rst_n (synchronous) empties both registers, zeroes the classifier state and
//   loads the register defaults (20, 1000, 300, 0).
// stall:
//   while m_tready is low the result is held; one more sample waits in the input
//   register, after which s_tready drops until the result is taken.
module button_press_classifier_unit
    import bpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [IN_W-1:0]    s_tdata,   // [0] raw_level, [32:1] time_ms, [33] begin_suppress
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata,   // [2:0] press_event, [3] suppressed, [4] debounced_level
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg    w_cfg;
    t_state  r_state;
    t_state  n_state;
    t_sample r_in;
    logic    r_in_valid;
    t_result r_out;
    t_result n_out;
    logic    r_out_valid;
    logic    w_proc;
    logic    w_s_fire;

    bpc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bpc_step u_step (
        .i_cfg    (w_cfg),
        .i_state  (r_state),
        .i_sample (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // the held sample moves on whenever the result slot is free or being drained
    assign w_proc   = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || w_proc;
    assign w_s_fire = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RST;
        end else begin
            if (w_s_fire) begin
                r_in_valid <= 1'b1;
            end else if (w_proc) begin
                r_in_valid <= 1'b0;
            end
            if (w_proc) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_fire) begin
            r_in.raw_level      <= s_tdata[0];
            r_in.time_ms        <= s_tdata[TIME_W:1];
            r_in.begin_suppress <= s_tdata[TIME_W+1];
        end
        if (w_proc) begin
            r_out <= n_out;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(OUT_W-EV_W-2){1'b0}}, r_out.debounced_level, r_out.suppressed,
                       r_out.press_event};

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("result valid right after reset");

    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> (r_in_valid && r_out_valid && !m_tready))
        else $error("input stalled without a blocked result");

    a_proc_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc |=> m_tvalid)
        else $error("processed sample produced no result");

    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (r_out.press_event <= EV_LONG_RELEASE))
        else $error("event code out of range");

    a_supp_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && r_out.suppressed) |-> (r_out.press_event == EV_NONE))
        else $error("event reported in suppress mode");

endmodule

@@ rtl/bpc_cfg.sv @@
// configuration register file on an apb-style port
// depends on bpc_pkg for the register map and reset values
module bpc_cfg
    import bpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms       <= DEBOUNCE_RST;
            r_cfg.long_press_ms     <= LONG_RST;
            r_cfg.double_tap_ms     <= DOUBLE_RST;
            r_cfg.single_on_release <= 1'b0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_DEBOUNCE:  r_cfg.debounce_ms       <= pwdata[MS_W-1:0];
                REG_LONG:      r_cfg.long_press_ms     <= pwdata[MS_W-1:0];
                REG_DOUBLE:    r_cfg.double_tap_ms     <= pwdata[MS_W-1:0];
                REG_SINGLE_ON: r_cfg.single_on_release <= pwdata[0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_DEBOUNCE:  prdata = {{(PDATA_W-MS_W){1'b0}}, r_cfg.debounce_ms};
            REG_LONG:      prdata = {{(PDATA_W-MS_W){1'b0}}, r_cfg.long_press_ms};
            REG_DOUBLE:    prdata = {{(PDATA_W-MS_W){1'b0}}, r_cfg.double_tap_ms};
            REG_SINGLE_ON: prdata = {{(PDATA_W-1){1'b0}}, r_cfg.single_on_release};
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/bpc_step.sv @@
// next-state and event logic for one button sample
// depends on bpc_pkg for state, config, sample and result types
module bpc_step
    import bpc_pkg::*;
(
    input  t_cfg    i_cfg,
    input  t_state  i_state,
    input  t_sample i_sample,
    output t_state  o_state,
    output t_result o_result
);

    logic              w_raw;
    logic [TIME_W-1:0] w_now;
    logic              w_supp;
    logic              w_settled;
    logic [TIME_W-1:0] w_chg;
    logic              w_prev;
    logic              w_rise;
    logic              w_fall;
    logic              w_long_hit;
    logic              w_win_hit;
    t_state            s1;
    t_state            s2;
    t_state            s3;
    t_event            ev1;
    t_event            ev2;
    t_event            ev3;

    assign w_raw  = i_sample.raw_level;
    assign w_now  = i_sample.time_ms;
    assign w_supp = i_state.suppress_flag || i_sample.begin_suppress;
    assign w_chg  = (w_raw != i_state.last_raw_level) ? w_now : i_state.change_stamp;
    assign w_settled = (w_now - w_chg) >= {{(TIME_W-MS_W){1'b0}}, i_cfg.debounce_ms};
    assign w_prev = i_state.stable_level;
    assign w_rise = w_settled && w_raw && !w_prev;
    assign w_fall = w_settled && !w_raw && w_prev;

    // debounce and edge handling
    always_comb begin
        s1 = i_state;
        ev1 = EV_NONE;
        s1.last_raw_level = w_raw;
        s1.change_stamp   = w_chg;
        s1.suppress_flag  = w_supp;
        if (w_settled) begin
            s1.stable_level = w_raw;
        end
        if (w_supp) begin
            // release while suppressed wipes the tap state and leaves the mode
            if (w_settled && !w_raw) begin
                s1.press_stamp         = '0;
                s1.first_tap_stamp     = '0;
                s1.tap_counter         = '0;
                s1.long_fired          = 1'b0;
                s1.awaiting_second_tap = 1'b0;
                s1.suppress_flag       = 1'b0;
            end
        end else if (w_rise) begin
            s1.press_stamp = w_now;
            s1.long_fired  = 1'b0;
            if (i_state.tap_counter != 2'd3) begin
                s1.tap_counter = i_state.tap_counter + 2'd1;
            end
            if (i_state.tap_counter == 2'd0) begin
                s1.first_tap_stamp     = w_now;
                s1.awaiting_second_tap = 1'b1;
            end
        end else if (w_fall) begin
            priority if (i_state.long_fired) begin
                ev1 = EV_LONG_RELEASE;
                s1.tap_counter = '0;
                s1.awaiting_second_tap = 1'b0;
            end else if (i_state.tap_counter >= 2'd2) begin
                ev1 = EV_DOUBLE;
                s1.tap_counter = '0;
                s1.awaiting_second_tap = 1'b0;
            end else if (i_state.tap_counter == 2'd1 && i_cfg.single_on_release) begin
                ev1 = EV_SINGLE;
                s1.tap_counter = '0;
                s1.awaiting_second_tap = 1'b0;
            end else begin
                // release with no reportable tap
                ev1 = EV_NONE;
            end
        end
    end

    // long press while held
    assign w_long_hit = !w_supp && s1.stable_level && !s1.long_fired && w_raw &&
        ((w_now - s1.press_stamp) >= {{(TIME_W-MS_W){1'b0}}, i_cfg.long_press_ms});

    always_comb begin
        s2  = s1;
        ev2 = ev1;
        if (w_long_hit) begin
            ev2 = EV_LONG;
            s2.long_fired = 1'b1;
            s2.tap_counter = '0;
            s2.awaiting_second_tap = 1'b0;
        end
    end

    // double-tap window expiry while released
    assign w_win_hit = !w_supp && s2.awaiting_second_tap && (s2.tap_counter != 2'd0) &&
        !s2.stable_level &&
        ((w_now - s2.first_tap_stamp) >= {{(TIME_W-MS_W){1'b0}}, i_cfg.double_tap_ms});

    always_comb begin
        s3  = s2;
        ev3 = ev2;
        if (w_win_hit) begin
            if (s2.tap_counter == 2'd1) begin
                ev3 = EV_SINGLE;
            end
            s3.tap_counter = '0;
            s3.awaiting_second_tap = 1'b0;
        end
    end

    assign o_state                  = s3;
    assign o_result.press_event     = ev3;
    assign o_result.suppressed      = w_supp;
    assign o_result.debounced_level = s3.stable_level;

endmodule
